@@ src/assert_macros.svh @@
// Shared assertion macros for the election engine checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/lee_pkg.sv @@
package lee_pkg;

   // Cluster limits
   localparam int MAX_NODES = 16;

   // Field widths
   localparam int TERM_W  = 31;
   localparam int NODE_W  = 4;
   localparam int SIZE_W  = 5;
   localparam int TALLY_W = 5;
   localparam int CSR_DATA_W = 5;

   localparam logic [TERM_W-1:0]  TERM_MAX  = {TERM_W{1'b1}};
   localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

   // Event codes
   typedef enum logic [2:0] {
      OP_VOTE_REQUEST = 3'd0,
      OP_VOTE_REPLY   = 3'd1,
      OP_APPEND       = 3'd2,
      OP_TIMEOUT      = 3'd3,
      OP_BEAT_TICK    = 3'd4
   } op_type;

   // Outgoing message codes
   typedef enum logic [2:0] {
      KIND_NONE        = 3'd0,
      KIND_VOTE_REPLY  = 3'd1,
      KIND_APPEND_REPLY = 3'd2,
      KIND_BCAST_VOTE  = 3'd3,
      KIND_BCAST_BEAT  = 3'd4
   } kind_type;

   // Node role
   typedef enum logic [1:0] {
      ROLE_FOLLOWER  = 2'd0,
      ROLE_CANDIDATE = 2'd1,
      ROLE_LEADER    = 2'd2
   } role_type;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_SELF_NODE    = 1'b0,
      CSR_CLUSTER_SIZE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]        operation;
      logic [TERM_W-1:0] msg_term;
      logic [NODE_W-1:0] claimed_node;
      logic [NODE_W-1:0] sender_node;
      logic              granted_in;
   } lee_req_type;

   typedef struct packed {
      logic [2:0]        send_kind;
      logic [TERM_W-1:0] send_term;
      logic              send_flag;
      logic              restart_election;
      logic              stop_election;
      logic              start_heartbeat;
      logic              stop_heartbeat;
      logic [1:0]        role_now;
      logic              leader_known;
      logic [NODE_W-1:0] leader_now;
   } lee_rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0] self_node;
      logic [SIZE_W-1:0] cluster_size;
   } lee_cfg_type;

   typedef struct packed {
      logic [TERM_W-1:0]  term;
      role_type           role;
      logic               vote_cast;
      logic [NODE_W-1:0]  vote_target;
      logic [TALLY_W-1:0] vote_tally;
      logic               leader_valid;
      logic [NODE_W-1:0]  leader_node;
      logic               beat_running;
   } lee_state_type;

   localparam lee_state_type STATE_RESET = '{
      term:         '0,
      role:         ROLE_FOLLOWER,
      vote_cast:    1'b0,
      vote_target:  '0,
      vote_tally:   '0,
      leader_valid: 1'b0,
      leader_node:  '0,
      beat_running: 1'b0
   };

   localparam lee_cfg_type CFG_RESET = '{
      self_node:    '0,
      cluster_size: 5'd3
   };

endpackage

@@ src/lee_csr.sv @@
module lee_csr import lee_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output lee_cfg_type           cfg
);

   lee_cfg_type cfg_ff;
   lee_cfg_type cfg_in;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SELF_NODE:    cfg_in.self_node    = csr_data[NODE_W-1:0];
            CSR_CLUSTER_SIZE: cfg_in.cluster_size = csr_data[SIZE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/lee_step.sv @@
module lee_step import lee_pkg::*; #(
   parameter int NODE_LIMIT = MAX_NODES
) (
   input  lee_req_type   req,
   input  lee_state_type cur,
   input  lee_cfg_type   cfg,
   output lee_state_type nxt,
   output lee_rsp_type   rsp
);

   // Largest cluster size that still counts toward the majority
   localparam int SIZE_FIELD_MAX = (1 << SIZE_W) - 1;
   localparam logic [SIZE_W-1:0] SIZE_CAP =
      SIZE_W'((NODE_LIMIT < SIZE_FIELD_MAX) ? NODE_LIMIT : SIZE_FIELD_MAX);

   logic               term_gt;
   logic               term_lt;
   logic               vote_ok;
   logic               is_candidate;
   logic [TALLY_W-1:0] tally_inc;
   logic [SIZE_W-1:0]  size_eff;
   logic [TALLY_W-1:0] majority;
   logic               win;
   logic               from_other;
   logic [TERM_W-1:0]  term_inc;

   // Compare terms and derive the shared conditions
   assign term_gt      = req.msg_term > cur.term;
   assign term_lt      = req.msg_term < cur.term;
   assign vote_ok      = !term_lt && (term_gt || !cur.vote_cast ||
                                      (cur.vote_target == req.claimed_node));
   assign is_candidate = (cur.role == ROLE_CANDIDATE);
   assign tally_inc    = (cur.vote_tally == TALLY_MAX) ? cur.vote_tally
                                                       : cur.vote_tally + TALLY_W'(1);
   assign size_eff     = (cfg.cluster_size > SIZE_CAP) ? SIZE_CAP : cfg.cluster_size;
   assign majority     = {1'b0, size_eff[SIZE_W-1:1]} + TALLY_W'(1);
   assign win          = is_candidate && !term_gt && req.granted_in && (tally_inc >= majority);
   assign from_other   = (req.sender_node != cfg.self_node);
   assign term_inc     = (cur.term == TERM_MAX) ? cur.term : cur.term + TERM_W'(1);

   // Next state
   always_comb begin
      nxt = cur;
      case (req.operation)
         OP_VOTE_REQUEST: begin
            if (!term_lt) begin
               if (term_gt) begin
                  nxt.term = req.msg_term;
                  if (cur.role == ROLE_LEADER) begin
                     nxt.beat_running = 1'b0;
                  end
                  nxt.role      = ROLE_FOLLOWER;
                  nxt.vote_cast = 1'b0;
               end
               if (vote_ok) begin
                  nxt.vote_cast   = 1'b1;
                  nxt.vote_target = req.claimed_node;
               end
            end
         end
         OP_VOTE_REPLY: begin
            if (is_candidate) begin
               if (term_gt) begin
                  nxt.term      = req.msg_term;
                  nxt.role      = ROLE_FOLLOWER;
                  nxt.vote_cast = 1'b0;
               end else if (req.granted_in) begin
                  nxt.vote_tally = tally_inc;
                  if (win) begin
                     nxt.role         = ROLE_LEADER;
                     nxt.leader_valid = 1'b1;
                     nxt.leader_node  = cfg.self_node;
                     nxt.vote_tally   = '0;
                     nxt.beat_running = 1'b1;
                  end
               end
            end
         end
         OP_APPEND: begin
            if (!term_lt) begin
               if (term_gt && cur.beat_running) begin
                  nxt.beat_running = 1'b0;
               end
               if (from_other) begin
                  nxt.term         = req.msg_term;
                  nxt.role         = ROLE_FOLLOWER;
                  nxt.leader_valid = 1'b1;
                  nxt.leader_node  = req.claimed_node;
                  nxt.vote_cast    = 1'b0;
               end
            end
         end
         OP_TIMEOUT: begin
            nxt.term         = term_inc;
            nxt.role         = ROLE_CANDIDATE;
            nxt.leader_valid = 1'b0;
            nxt.vote_cast    = 1'b1;
            nxt.vote_target  = cfg.self_node;
            nxt.vote_tally   = '0;
         end
         default: nxt = cur;
      endcase
   end

   // Response fields
   always_comb begin
      rsp = '0;
      case (req.operation)
         OP_VOTE_REQUEST: begin
            rsp.send_kind        = KIND_VOTE_REPLY;
            rsp.send_term        = nxt.term;
            rsp.send_flag        = vote_ok;
            rsp.restart_election = vote_ok;
            rsp.stop_heartbeat   = term_gt && (cur.role == ROLE_LEADER);
         end
         OP_VOTE_REPLY: begin
            rsp.stop_election   = win;
            rsp.start_heartbeat = win;
         end
         OP_APPEND: begin
            if (term_lt) begin
               rsp.send_kind = KIND_APPEND_REPLY;
               rsp.send_term = cur.term;
            end else begin
               rsp.stop_heartbeat = term_gt && cur.beat_running;
               if (from_other) begin
                  rsp.send_kind        = KIND_APPEND_REPLY;
                  rsp.send_term        = req.msg_term;
                  rsp.send_flag        = 1'b1;
                  rsp.restart_election = 1'b1;
               end
            end
         end
         OP_TIMEOUT: begin
            rsp.send_kind        = KIND_BCAST_VOTE;
            rsp.send_term        = term_inc;
            rsp.restart_election = 1'b1;
         end
         OP_BEAT_TICK: begin
            if (cur.role == ROLE_LEADER) begin
               rsp.send_kind = KIND_BCAST_BEAT;
               rsp.send_term = cur.term;
            end
         end
         default: rsp.send_kind = KIND_NONE;
      endcase
      rsp.role_now     = nxt.role;
      rsp.leader_known = nxt.leader_valid;
      rsp.leader_now   = nxt.leader_valid ? nxt.leader_node : '0;
   end

endmodule

@@ src/leader_election_engine_core.sv @@
// A request is held in the request register, then moves to the response register when
// that register is free. Throughput: one request per cycle unless a stalled response
// holds the flow; the term, role and vote state update in the same edge that registers
// a response, so the next request sees it.
// Reset (synchronous, active high) clears the node state to follower at term 0,
// empties both stages and sets self_node to 0 and cluster_size to 3.
module leader_election_engine_core import lee_pkg::*; #(
   parameter int NODE_LIMIT = MAX_NODES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lee_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lee_rsp_type           rsp_data,
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   lee_cfg_type   cfg;
   logic          req_valid_ff, req_valid_in;
   lee_req_type   req_data_ff, req_data_in;
   lee_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   lee_rsp_type   rsp_data_ff, rsp_data_in;
   lee_state_type step_state;
   lee_rsp_type   step_rsp;
   logic          advance;
   logic          fire;

   lee_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lee_step #(
      .NODE_LIMIT (NODE_LIMIT)
   ) u_step (
      .req (req_data_ff),
      .cur (state_ff),
      .cfg (cfg),
      .nxt (step_state),
      .rsp (step_rsp)
   );

   // Move the held request into the response register when it is free
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
         if (req_valid) begin
            req_data_in = req_data;
         end
      end
      state_in     = fire ? step_state : state_ff;
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = fire ? step_rsp : rsp_data_ff;
   end

   // Control and node state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/lee_checker.sv @@
`include "assert_macros.svh"

module lee_checker import lee_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input lee_rsp_type rsp_data
);

   // Hold a stalled response
   `ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "response changed while stalled")

   // Stall requests only while the response side is blocked
   `ASSERT_CLK(a_stall_cause, req_stall |-> rsp_valid && rsp_stall, "request stalled with response side free")

   // Drop the response after reset
   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")

   // Zero the message fields when nothing is sent
   `ASSERT_CLK(a_idle_msg, rsp_valid && (rsp_data.send_kind == KIND_NONE) |-> (rsp_data.send_term == '0) && !rsp_data.send_flag, "message fields set with nothing sent")

   // Zero the leader number when no leader is known
   `ASSERT_CLK(a_leader_zero, rsp_valid && !rsp_data.leader_known |-> rsp_data.leader_now == '0, "leader number without a known leader")

endmodule

bind leader_election_engine_core lee_checker u_checker (.*);

@@ bench/election_checker.sv @@
`timescale 1ns / 100ps

module election_checker import lee_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  lee_req_type           req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  lee_rsp_type           rsp_data,
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fault_count,
   output int                    replies_owed,
   output int                    replies_checked,
   output int                    elections_won
);

   localparam int REPORT_LIMIT = 10;

   // Shadow copy of the node state and its registers
   lee_state_type node;
   lee_cfg_type   cfg;

   lee_rsp_type   expected_replies[$];
   lee_rsp_type   predicted;
   lee_rsp_type   oldest;
   int            fails;
   int            checked;
   int            wins;

   // Votes needed for a majority; oversized clusters count as the node limit
   function automatic int votes_to_win();
      int members;
      members = (int'(cfg.cluster_size) > MAX_NODES) ? MAX_NODES : int'(cfg.cluster_size);
      return members / 2 + 1;
   endfunction

   function automatic string reply_text(lee_rsp_type r);
      return {$sformatf("kind=%0d term=%0d flag=%0b restart_el=%0b stop_el=%0b ",
                        r.send_kind, r.send_term, r.send_flag, r.restart_election,
                        r.stop_election),
              $sformatf("start_hb=%0b stop_hb=%0b role=%0d leader=%0b/%0d",
                        r.start_heartbeat, r.stop_heartbeat,
                        r.role_now, r.leader_known, r.leader_now)};
   endfunction

   // Advance the shadow node by one request and build the reply it owes
   task automatic apply_event(input lee_req_type ev, output lee_rsp_type res);
      res = '0;
      case (ev.operation)
         OP_VOTE_REQUEST: begin
            if (ev.msg_term >= node.term) begin
               if (ev.msg_term > node.term) begin
                  node.term = ev.msg_term;
                  if (node.role == ROLE_LEADER) begin
                     res.stop_heartbeat = 1'b1;
                     node.beat_running = 1'b0;
                  end
                  node.role = ROLE_FOLLOWER;
                  node.vote_cast = 1'b0;
               end
               if (!node.vote_cast || node.vote_target == ev.claimed_node) begin
                  res.send_flag = 1'b1;
                  res.restart_election = 1'b1;
                  node.vote_cast = 1'b1;
                  node.vote_target = ev.claimed_node;
               end
            end
            res.send_kind = KIND_VOTE_REPLY;
            res.send_term = node.term;
         end
         OP_VOTE_REPLY: begin
            // only a candidate listens to replies
            if (node.role == ROLE_CANDIDATE) begin
               if (ev.msg_term > node.term) begin
                  node.term = ev.msg_term;
                  node.role = ROLE_FOLLOWER;
                  node.vote_cast = 1'b0;
               end else if (ev.granted_in) begin
                  if (node.vote_tally != TALLY_MAX)
                     node.vote_tally++;
                  if (int'(node.vote_tally) >= votes_to_win()) begin
                     node.role = ROLE_LEADER;
                     node.leader_valid = 1'b1;
                     node.leader_node = cfg.self_node;
                     node.vote_tally = '0;
                     node.beat_running = 1'b1;
                     res.stop_election = 1'b1;
                     res.start_heartbeat = 1'b1;
                     wins++;
                  end
               end
            end
         end
         OP_APPEND: begin
            if (ev.msg_term < node.term) begin
               res.send_kind = KIND_APPEND_REPLY;
               res.send_term = node.term;
            end else begin
               if (ev.msg_term > node.term && node.beat_running) begin
                  res.stop_heartbeat = 1'b1;
                  node.beat_running = 1'b0;
               end
               // drop our own heartbeat coming back
               if (ev.sender_node != cfg.self_node) begin
                  node.term = ev.msg_term;
                  node.role = ROLE_FOLLOWER;
                  node.leader_valid = 1'b1;
                  node.leader_node = ev.claimed_node;
                  node.vote_cast = 1'b0;
                  res.restart_election = 1'b1;
                  res.send_kind = KIND_APPEND_REPLY;
                  res.send_term = node.term;
                  res.send_flag = 1'b1;
               end
            end
         end
         OP_TIMEOUT: begin
            // hold the term at its ceiling
            if (node.term != TERM_MAX)
               node.term++;
            node.role = ROLE_CANDIDATE;
            node.leader_valid = 1'b0;
            node.vote_cast = 1'b1;
            node.vote_target = cfg.self_node;
            node.vote_tally = '0;
            res.restart_election = 1'b1;
            res.send_kind = KIND_BCAST_VOTE;
            res.send_term = node.term;
         end
         OP_BEAT_TICK: begin
            if (node.role == ROLE_LEADER) begin
               res.send_kind = KIND_BCAST_BEAT;
               res.send_term = node.term;
            end
         end
         default: ;
      endcase
      res.role_now = node.role;
      res.leader_known = node.leader_valid;
      res.leader_now = node.leader_valid ? node.leader_node : '0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         node = STATE_RESET;
         cfg = CFG_RESET;
         expected_replies.delete();
      end else begin
         // track register writes
         if (csr_write) begin
            if (csr_index == CSR_SELF_NODE)
               cfg.self_node = csr_data[NODE_W-1:0];
            else
               cfg.cluster_size = csr_data;
         end

         // compare each delivered reply with the oldest one owed
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               fails++;
               if (fails <= REPORT_LIMIT)
                  $display("%0t: reply with none owed: %s", $time, reply_text(rsp_data));
            end else begin
               oldest = expected_replies.pop_front();
               checked++;
               if (rsp_data.send_kind !== oldest.send_kind ||
                   rsp_data.send_term !== oldest.send_term ||
                   rsp_data.send_flag !== oldest.send_flag ||
                   rsp_data.restart_election !== oldest.restart_election ||
                   rsp_data.stop_election !== oldest.stop_election ||
                   rsp_data.start_heartbeat !== oldest.start_heartbeat ||
                   rsp_data.stop_heartbeat !== oldest.stop_heartbeat ||
                   rsp_data.role_now !== oldest.role_now ||
                   rsp_data.leader_known !== oldest.leader_known ||
                   rsp_data.leader_now !== oldest.leader_now) begin
                  fails++;
                  if (fails <= REPORT_LIMIT) begin
                     $display("%0t: reply %0d mismatch", $time, checked);
                     $display("   expected %s", reply_text(oldest));
                     $display("   actual   %s", reply_text(rsp_data));
                  end
               end
            end
         end

         // predict the reply of each accepted request
         if (req_valid && !req_stall) begin
            apply_event(req_data, predicted);
            expected_replies.push_back(predicted);
         end
      end
      fault_count <= fails;
      replies_owed <= expected_replies.size();
      replies_checked <= checked;
      elections_won <= wins;
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import lee_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 11;
   localparam int HOLD_CYCLES   = 64;
   localparam int SETTLE_CYCLES = 6;
   localparam int RUN_CYCLES    = 200000;
   localparam int NODE_LAST     = (1 << NODE_W) - 1;
   localparam logic [2:0] OP_FIRST_SPARE = 3'd5;
   localparam logic [2:0] OP_LAST_SPARE  = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   lee_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   lee_rsp_type           rsp_data;
   logic                  csr_write = 1'b0;
   logic [0:0]            csr_index = CSR_SELF_NODE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fault_count;
   int replies_owed;
   int replies_checked;
   int elections_won;

   logic              sender_gaps = 1'b1;
   logic              receiver_gaps = 1'b1;
   logic              hold_output = 1'b0;
   logic [TERM_W-1:0] cur_term = '0;
   logic [NODE_W-1:0] cur_self = '0;
   logic [NODE_W-1:0] last_claimed = '0;
   int                campaign_left = 0;
   int                events_sent = 0;
   int                settings_used = 1;

   always #HALF_PERIOD clock = ~clock;

   leader_election_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   election_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fault_count     (fault_count),
      .replies_owed    (replies_owed),
      .replies_checked (replies_checked),
      .elections_won   (elections_won)
   );

   // Receiver: random stalls, or one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output <= 1'b0;
         end else begin
            rsp_stall <= receiver_gaps && ($urandom_range(99) < 9);
         end
      end
   end

   // Give up on a hung run
   initial begin
      #(2 * HALF_PERIOD * RUN_CYCLES);
      $display("Verification failed");
      $finish;
   end

   function automatic lee_req_type make_ev(input logic [2:0] op, input logic [TERM_W-1:0] term,
                                           input int claimed, input int sender, input bit granted);
      lee_req_type ev;
      ev.operation = op;
      ev.msg_term = term;
      ev.claimed_node = NODE_W'(claimed);
      ev.sender_node = NODE_W'(sender);
      ev.granted_in = granted;
      return ev;
   endfunction

   // Term near the current one: mostly equal, sometimes newer or older
   function automatic logic [TERM_W-1:0] pick_term();
      int     pick;
      longint t;
      pick = $urandom_range(99);
      t = longint'(cur_term);
      if (pick < 15)
         t = t + $urandom_range(1, 3);
      else if (pick < 30)
         t = t - $urandom_range(1, 4);
      if (t < 0)
         t = 0;
      else if (t > longint'(TERM_MAX))
         t = longint'(TERM_MAX);
      return t[TERM_W-1:0];
   endfunction

   // Offer one request, with an occasional gap ahead of it
   task automatic offer_event(input lee_req_type ev);
      if (sender_gaps && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= ev;
      do @(posedge clock); while (req_stall);
      events_sent++;
      // follow the cluster term roughly
      case (ev.operation)
         OP_VOTE_REQUEST, OP_VOTE_REPLY, OP_APPEND: begin
            if (ev.msg_term > cur_term)
               cur_term = ev.msg_term;
         end
         OP_TIMEOUT: begin
            if (cur_term != TERM_MAX)
               cur_term++;
         end
         default: ;
      endcase
   endtask

   // Drop valid and wait until every reply has come back
   task automatic await_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_node(input logic [CSR_DATA_W-1:0] self_val,
                                 input logic [CSR_DATA_W-1:0] size_val);
      csr_write <= 1'b1;
      csr_index <= CSR_SELF_NODE;
      csr_data <= self_val;
      @(posedge clock);
      csr_index <= CSR_CLUSTER_SIZE;
      csr_data <= size_val;
      @(posedge clock);
      csr_write <= 1'b0;
      cur_self = self_val[NODE_W-1:0];
      settings_used++;
   endtask

   // Mostly election campaigns with random content, the rest is traffic and noise
   task automatic draw_event(output lee_req_type ev);
      int pick;
      ev.claimed_node = NODE_W'($urandom_range(NODE_LAST));
      ev.sender_node = NODE_W'($urandom_range(NODE_LAST));
      ev.granted_in = 1'($urandom_range(1));
      ev.msg_term = pick_term();
      if (campaign_left > 0) begin
         campaign_left--;
         ev.operation = OP_VOTE_REPLY;
         ev.granted_in = ($urandom_range(99) < 90);
         if (ev.msg_term > cur_term && $urandom_range(99) < 95)
            ev.msg_term = cur_term;
      end else begin
         pick = $urandom_range(99);
         if (pick < 14) begin
            ev.operation = OP_TIMEOUT;
            ev.msg_term = TERM_W'($urandom());
            campaign_left = $urandom_range(0, 10);
         end else if (pick < 28) begin
            ev.operation = OP_VOTE_REPLY;
         end else if (pick < 46) begin
            ev.operation = OP_VOTE_REQUEST;
            if ($urandom_range(1))
               ev.claimed_node = last_claimed;
            last_claimed = ev.claimed_node;
         end else if (pick < 66) begin
            ev.operation = OP_APPEND;
            if ($urandom_range(99) < 12)
               ev.sender_node = cur_self;
            else if ($urandom_range(1))
               ev.sender_node = ev.claimed_node;
         end else if (pick < 94) begin
            ev.operation = OP_BEAT_TICK;
            ev.msg_term = TERM_W'($urandom());
         end else begin
            ev.operation = 3'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
            ev.msg_term = TERM_W'($urandom());
         end
      end
   endtask

   // One register setting with a run of random requests
   task automatic run_phase(input logic [CSR_DATA_W-1:0] self_val,
                            input logic [CSR_DATA_W-1:0] size_val, input int count,
                            input bit gaps, input bit pressure, input bit near_ceiling);
      int          i;
      lee_req_type ev;
      await_quiet();
      configure_node(self_val, size_val);
      sender_gaps = gaps;
      receiver_gaps <= gaps;
      campaign_left = 0;
      // jump close to the term ceiling so timeouts saturate it
      if (near_ceiling)
         offer_event(make_ev(OP_VOTE_REQUEST, TERM_MAX - TERM_W'(12), 1, 1, 1'b0));
      for (i = 0; i < count; i++) begin
         if (pressure && i == count / 3)
            hold_output <= 1'b1;
         if (i == count / 2)
            await_quiet();
         draw_event(ev);
         offer_event(ev);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: default node 0 in a cluster of three
      offer_event(make_ev(OP_BEAT_TICK, TERM_MAX, 15, 15, 1'b1));
      offer_event(make_ev(OP_VOTE_REPLY, '0, 15, 15, 1'b1));     // ignored, not a candidate
      offer_event(make_ev(OP_VOTE_REQUEST, '0, 5, 5, 1'b0));
      offer_event(make_ev(OP_VOTE_REQUEST, '0, 6, 6, 1'b0));     // already voted
      offer_event(make_ev(OP_VOTE_REQUEST, '0, 5, 5, 1'b0));     // same candidate again
      offer_event(make_ev(OP_APPEND, '0, 7, 7, 1'b0));
      offer_event(make_ev(OP_APPEND, '0, 0, 0, 1'b0));           // own heartbeat
      offer_event(make_ev(OP_TIMEOUT, '0, 0, 0, 1'b0));
      offer_event(make_ev(OP_VOTE_REPLY, 1, 1, 1, 1'b1));
      offer_event(make_ev(OP_VOTE_REPLY, '0, 1, 1, 1'b1));       // repeat with older term
      offer_event(make_ev(OP_BEAT_TICK, '0, 0, 0, 1'b0));
      offer_event(make_ev(OP_APPEND, 1, 3, 3, 1'b0));            // leader demoted, timer left on
      offer_event(make_ev(OP_TIMEOUT, '0, 0, 0, 1'b0));
      offer_event(make_ev(OP_VOTE_REPLY, 5, 2, 2, 1'b1));        // newer term ends the campaign
      offer_event(make_ev(OP_APPEND, 3, 2, 2, 1'b1));            // stale append
      offer_event(make_ev(OP_VOTE_REQUEST, 4, 2, 2, 1'b0));      // stale vote request
      offer_event(make_ev(OP_FIRST_SPARE, TERM_MAX, 15, 15, 1'b1));
      offer_event(make_ev(OP_TIMEOUT, '0, 0, 0, 1'b0));
      offer_event(make_ev(OP_VOTE_REPLY, 6, 2, 2, 1'b1));
      offer_event(make_ev(OP_VOTE_REPLY, 6, 3, 3, 1'b1));
      offer_event(make_ev(OP_TIMEOUT, '0, 0, 0, 1'b0));          // leader times out
      offer_event(make_ev(OP_BEAT_TICK, '0, 0, 0, 1'b0));
      offer_event(make_ev(OP_VOTE_REPLY, 7, 4, 4, 1'b1));
      offer_event(make_ev(OP_VOTE_REPLY, 7, 5, 5, 1'b1));
      offer_event(make_ev(OP_APPEND, 9, 0, 0, 1'b0));            // own heartbeat, newer term
      offer_event(make_ev(OP_VOTE_REQUEST, 10, 4, 4, 1'b0));     // newer term unseats leader

      // Random phases over several register settings
      run_phase(5'd0, 5'd3, 300, 1'b1, 1'b0, 1'b0);
      run_phase(5'd15, 5'd16, 300, 1'b0, 1'b0, 1'b0);
      run_phase(5'd17, 5'd1, 250, 1'b1, 1'b1, 1'b0);
      run_phase(5'd7, 5'd0, 250, 1'b1, 1'b0, 1'b0);
      run_phase(5'd9, 5'd31, 300, 1'b1, 1'b0, 1'b0);
      run_phase(5'd15, 5'd5, 300, 1'b1, 1'b0, 1'b1);
      await_quiet();

      $display("Covered %0d requests under %0d register settings, %0d replies checked.",
               events_sent, settings_used, replies_checked);
      $display("The node won %0d elections; the last phase ran at the term ceiling.",
               elections_won);
      if (fault_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/lee_pkg.sv
src/lee_csr.sv
src/lee_step.sv
src/leader_election_engine_core.sv
src/lee_checker.sv
bench/election_checker.sv
bench/testbench.sv
